@@ rtl/chls_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// chls_pkg: shared types and constants
// Widths, constants, controller states and the controller/datapath
// command and status bundles of the color hue and light smoother.
// ----------------------------------------------------------------------------
package chls_pkg;

  // Sample width and masking
  localparam int unsigned SAMPLE_BITS = 16;
  localparam int unsigned FIELD_W     = 16;
  localparam logic [FIELD_W-1:0] SAMPLE_MASK = {FIELD_W{1'b1}} >> (FIELD_W - SAMPLE_BITS);

  // Stream payload widths
  localparam int unsigned IN_DATA_W  = 4 * FIELD_W;
  localparam int unsigned HUE_W      = 16;
  localparam int unsigned LIGHT_W    = 24;
  localparam int unsigned OUT_DATA_W = HUE_W + 2 * LIGHT_W;

  // Smoothing coefficient, Q1.16
  localparam int unsigned COEF_W = 17;
  localparam logic [COEF_W-1:0] COEF_ONE   = 17'd65536;
  localparam logic [COEF_W-1:0] COEF_RESET = 17'd60293;

  // Configuration port
  localparam int unsigned APB_ADDR_W = 2;
  localparam int unsigned APB_DATA_W = 32;
  localparam logic [APB_ADDR_W-1:0] REG_SMOOTHING_COEF = 2'd0;

  // Hue arithmetic: numerator magnitude, product and quotient widths
  localparam int unsigned NUM_W   = 20;  // signed hue numerator
  localparam int unsigned MAG_W   = 19;
  localparam int unsigned HPROD_W = 31;
  localparam int unsigned QUO_W   = 15;  // quotient never exceeds 19200
  localparam int unsigned CNT_W   = $clog2(QUO_W);
  localparam logic [HPROD_W-1:0] HUE_SCALE = 31'd3840;
  localparam logic signed [HUE_W-1:0] HUE_MIN = -16'sd3840;
  localparam logic signed [HUE_W-1:0] HUE_MAX = 16'sd19200;

  // Smoothing arithmetic widths
  localparam int unsigned DIFF_W  = LIGHT_W + 1;
  localparam int unsigned SPROD_W = DIFF_W + COEF_W + 1;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_MUL,
    ST_DIV,
    ST_OUT
  } ctrl_state_e;

  // Controller to datapath commands
  typedef struct packed {
    logic capture;   // take the input request
    logic prep;      // max/min, numerator, light difference
    logic mul;       // products, divider load
    logic div_step;  // one restoring divide step
    logic commit;    // load output register, update smoothed light
  } ctrl_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic out_free;  // output register can take a new result
  } dp_sts_t;

endpackage
`default_nettype wire

@@ rtl/chls_dpath.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// chls_dpath: hue and smoothing datapath
// Sample registers, hue numerator, shared-step restoring divider, smoothing
// multiply, smoothed light state and the output register.
// ----------------------------------------------------------------------------
module chls_dpath (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire chls_pkg::ctrl_cmd_t               cmd_i,
  output chls_pkg::dp_sts_t                      sts_o,
  input  wire logic [chls_pkg::IN_DATA_W-1:0]    sample_i,
  input  wire logic [chls_pkg::COEF_W-1:0]       coef_i,
  output logic                                   m_tvalid_o,
  input  wire logic                              m_tready_i,
  output logic [chls_pkg::OUT_DATA_W-1:0]        result_o
);

  localparam int unsigned FW = chls_pkg::FIELD_W;

  // Captured sample
  logic [FW-1:0] red_q, green_q, blue_q, amb_q;

  // Prep stage
  logic [FW-1:0] hi, lo, span;
  logic          red_max, green_max;
  logic signed [chls_pkg::NUM_W-1:0] num_base, num_part, num;
  logic [chls_pkg::NUM_W-1:0] num_abs;
  logic [chls_pkg::LIGHT_W-1:0] amb_fix;
  logic signed [chls_pkg::DIFF_W-1:0] diff;
  logic [chls_pkg::DIFF_W-1:0] diff_abs;

  logic [FW-1:0]                      span_q;
  logic                               neg_q, zero_q;
  logic [chls_pkg::MAG_W-1:0]         mag_q;
  logic signed [chls_pkg::DIFF_W-1:0] diff_q;
  logic [chls_pkg::LIGHT_W-1:0]       delta_q;

  // Multiply and divide
  logic [chls_pkg::HPROD_W-1:0]        hprod;
  logic signed [chls_pkg::SPROD_W-1:0] sprod_d, sprod_q;
  logic [FW-1:0]                       rem_q;
  logic [chls_pkg::QUO_W-1:0]          quo_q;
  logic [FW:0]                         trial;
  logic                                fits;

  // Result and state
  logic [chls_pkg::LIGHT_W-1:0]        light_q;
  logic signed [chls_pkg::SPROD_W-1:0] sshift;
  logic [chls_pkg::DIFF_W-1:0]         next_sum;
  logic [chls_pkg::LIGHT_W-1:0]        next_light;
  logic [chls_pkg::HUE_W-1:0]          hue_mag, hue_val;
  logic [chls_pkg::HUE_W-1:0]          out_hue_q;
  logic [chls_pkg::LIGHT_W-1:0]        out_chg_q, out_smooth_q;
  logic                                out_valid_q, out_valid_d;

  // Input capture, masked to the sample width
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      red_q   <= sample_i[FW-1:0]      & chls_pkg::SAMPLE_MASK;
      green_q <= sample_i[2*FW-1:FW]   & chls_pkg::SAMPLE_MASK;
      blue_q  <= sample_i[3*FW-1:2*FW] & chls_pkg::SAMPLE_MASK;
      amb_q   <= sample_i[4*FW-1:3*FW] & chls_pkg::SAMPLE_MASK;
    end
  end

  // Max/min and hue numerator; red wins ties, then green
  always_comb begin
    hi = red_q;
    lo = red_q;
    if (green_q > hi) hi = green_q;
    if (blue_q > hi)  hi = blue_q;
    if (green_q < lo) lo = green_q;
    if (blue_q < lo)  lo = blue_q;
    span      = hi - lo;
    red_max   = (red_q >= hi);
    green_max = (green_q >= hi);
    if (red_max) begin
      num_base = '0;
      num_part = $signed({4'b0, green_q}) - $signed({4'b0, blue_q});
    end else if (green_max) begin
      num_base = $signed({3'b0, span, 1'b0});
      num_part = $signed({4'b0, blue_q}) - $signed({4'b0, red_q});
    end else begin
      num_base = $signed({2'b0, span, 2'b0});
      num_part = $signed({4'b0, red_q}) - $signed({4'b0, green_q});
    end
    num     = num_base + num_part;
    num_abs = num[chls_pkg::NUM_W-1] ? 20'(-num) : 20'(num);
  end

  // Light difference against the stored smoothed value
  assign amb_fix  = {amb_q, 8'b0};
  assign diff     = $signed({1'b0, light_q}) - $signed({1'b0, amb_fix});
  assign diff_abs = diff[chls_pkg::DIFF_W-1] ? 25'(-diff) : 25'(diff);

  always_ff @(posedge clk_i) begin
    if (cmd_i.prep) begin
      span_q  <= span;
      zero_q  <= (span == '0);
      neg_q   <= num[chls_pkg::NUM_W-1];
      mag_q   <= num_abs[chls_pkg::MAG_W-1:0];
      diff_q  <= diff;
      delta_q <= diff_abs[chls_pkg::LIGHT_W-1:0];
    end
  end

  // Scaled numerator and smoothing product
  assign hprod   = 31'(mag_q) * chls_pkg::HUE_SCALE;
  assign sprod_d = 43'(diff_q) * 43'($signed({1'b0, coef_i}));

  // Restoring divider, one quotient bit per step
  assign trial = {rem_q, quo_q[chls_pkg::QUO_W-1]};
  assign fits  = (trial >= {1'b0, span_q});

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul) begin
      sprod_q <= sprod_d;
      rem_q   <= hprod[chls_pkg::HPROD_W-1:chls_pkg::QUO_W];
      quo_q   <= hprod[chls_pkg::QUO_W-1:0];
    end else if (cmd_i.div_step) begin
      rem_q <= fits ? 16'(trial - {1'b0, span_q}) : trial[FW-1:0];
      quo_q <= {quo_q[chls_pkg::QUO_W-2:0], fits};
    end
  end

  // New smoothed value: amb + floor(c * (old - amb) / 2^16)
  assign sshift     = sprod_q >>> 16;
  assign next_sum   = 25'(amb_fix) + 25'(sshift);
  assign next_light = next_sum[chls_pkg::LIGHT_W-1:0];

  // Signed hue, truncated toward zero
  assign hue_mag = {1'b0, quo_q};
  always_comb begin
    if (zero_q)     hue_val = '0;
    else if (neg_q) hue_val = -hue_mag;
    else            hue_val = hue_mag;
  end

  // Smoothed light state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      light_q <= '0;
    end else if (cmd_i.commit) begin
      light_q <= next_light;
    end
  end

  // Output register
  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      out_hue_q    <= hue_val;
      out_chg_q    <= delta_q;
      out_smooth_q <= next_light;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_i.commit)    out_valid_d = 1'b1;
    else if (m_tready_i) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  assign sts_o.out_free = !out_valid_q || m_tready_i;
  assign m_tvalid_o     = out_valid_q;
  assign result_o       = {out_smooth_q, out_chg_q, out_hue_q};

`ifndef SYNTHESIS
  // A committed result shows up on the output next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.commit |=> out_valid_q)
    else $error("commit did not raise output valid");

  // Hue stays inside the unwrapped range
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> ($signed(out_hue_q) >= chls_pkg::HUE_MIN &&
                     $signed(out_hue_q) <= chls_pkg::HUE_MAX))
    else $error("hue out of range");

  // Smoothed state only moves on commit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !cmd_i.commit |=> $stable(light_q))
    else $error("smoothed light changed without commit");
`endif

endmodule
`default_nettype wire

@@ rtl/chls_ctrl.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// chls_ctrl: sequencer
// Steps one request through prep, multiply, divide and output commit.
// ----------------------------------------------------------------------------
module chls_ctrl (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                s_tvalid_i,
  output logic                     s_tready_o,
  input  wire chls_pkg::dp_sts_t   sts_i,
  output chls_pkg::ctrl_cmd_t      cmd_o
);

  chls_pkg::ctrl_state_e state_q, state_d;
  logic [chls_pkg::CNT_W-1:0] cnt_q, cnt_d;
  logic last_step;

  assign last_step = (cnt_q == chls_pkg::CNT_W'(chls_pkg::QUO_W - 1));

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      chls_pkg::ST_IDLE: if (s_tvalid_i) state_d = chls_pkg::ST_PREP;
      chls_pkg::ST_PREP: state_d = chls_pkg::ST_MUL;
      chls_pkg::ST_MUL:  state_d = chls_pkg::ST_DIV;
      chls_pkg::ST_DIV:  if (last_step) state_d = chls_pkg::ST_OUT;
      chls_pkg::ST_OUT:  if (sts_i.out_free) state_d = chls_pkg::ST_IDLE;
      default:           state_d = chls_pkg::ST_IDLE;
    endcase
  end

  // Divide step counter
  always_comb begin
    cnt_d = cnt_q;
    if (state_q == chls_pkg::ST_MUL)      cnt_d = '0;
    else if (state_q == chls_pkg::ST_DIV) cnt_d = cnt_q + chls_pkg::CNT_W'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= chls_pkg::ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  // Outputs
  always_comb begin
    s_tready_o       = 1'b0;
    cmd_o            = '0;
    case (state_q)
      chls_pkg::ST_IDLE: begin
        s_tready_o    = 1'b1;
        cmd_o.capture = s_tvalid_i;
      end
      chls_pkg::ST_PREP: cmd_o.prep     = 1'b1;
      chls_pkg::ST_MUL:  cmd_o.mul      = 1'b1;
      chls_pkg::ST_DIV:  cmd_o.div_step = 1'b1;
      chls_pkg::ST_OUT:  cmd_o.commit   = sts_i.out_free;
      default: ;
    endcase
  end

`ifndef SYNTHESIS
  // Never overwrite a result that is still waiting
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.commit |-> sts_i.out_free)
    else $error("commit into a full output register");

  // A taken request starts the prep step next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.capture |=> cmd_o.prep)
    else $error("capture not followed by prep");

  // Divide runs exactly the quotient width
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.div_step && last_step) |=> (state_q == chls_pkg::ST_OUT))
    else $error("divider did not finish on its last step");
`endif

endmodule
`default_nettype wire

@@ rtl/color_hue_and_light_smoother_unit.sv @@
`default_nettype none
// Sequence: a request accepted on the input passes through prep, multiply, the
//   15-step restoring divide for the hue quotient and commit to output valid.
// Flow: a new request is taken only once the previous one has committed;
//   the output register holds a result while the next runs.
// Reset: asynchronous, active low; clears the smoothed light to zero, loads the
//   smoothing coefficient with 60293 and empties the output register.
// ----------------------------------------------------------------------------
// color_hue_and_light_smoother_unit: top level
// Hue from RGB samples and exponential smoothing of the ambient level,
// with an APB register for the smoothing coefficient.
// ----------------------------------------------------------------------------
module color_hue_and_light_smoother_unit (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  // tdata: red_level, green_level, blue_level, ambient_level (16 bits each)
  input  wire logic [chls_pkg::IN_DATA_W-1:0]      s_axis_tdata_i,
  input  wire logic                                s_axis_tvalid_i,
  output logic                                     s_axis_tready_o,
  // tdata: hue_angle (16), light_change (24), light_smoothed (24)
  output logic [chls_pkg::OUT_DATA_W-1:0]          m_axis_tdata_o,
  output logic                                     m_axis_tvalid_o,
  input  wire logic                                m_axis_tready_i,
  input  wire logic                                psel,
  input  wire logic                                penable,
  input  wire logic                                pwrite,
  input  wire logic [chls_pkg::APB_ADDR_W-1:0]     paddr,
  input  wire logic [chls_pkg::APB_DATA_W-1:0]     pwdata,
  output logic [chls_pkg::APB_DATA_W-1:0]          prdata,
  output logic                                     pready
);

  chls_pkg::ctrl_cmd_t cmd;
  chls_pkg::dp_sts_t   sts;

  logic [chls_pkg::COEF_W-1:0] coef_q, coef_d, wr_coef;
  logic                        coef_we;

  // Coefficient register; the low 17 bits are written and values above one saturate
  assign pready  = 1'b1;
  assign coef_we = psel && penable && pwrite && pready &&
                   (paddr == chls_pkg::REG_SMOOTHING_COEF);
  assign wr_coef = pwdata[chls_pkg::COEF_W-1:0];
  assign coef_d  = (wr_coef > chls_pkg::COEF_ONE) ? chls_pkg::COEF_ONE : wr_coef;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_q <= chls_pkg::COEF_RESET;
    end else if (coef_we) begin
      coef_q <= coef_d;
    end
  end

  // Read back
  assign prdata = (paddr == chls_pkg::REG_SMOOTHING_COEF) ? 32'(coef_q) : '0;

  chls_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid_i),
    .s_tready_o (s_axis_tready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  chls_dpath u_dpath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .sample_i   (s_axis_tdata_i),
    .coef_i     (coef_q),
    .m_tvalid_o (m_axis_tvalid_o),
    .m_tready_i (m_axis_tready_i),
    .result_o   (m_axis_tdata_o)
  );

endmodule
`default_nettype wire

@@ tb/color_hue_and_light_smoother_unit_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// color_hue_and_light_smoother_unit_tb: self-checking testbench
// Streams color samples into the unit with random source gaps and sink
// stalls. It predicts hue, light change and smoothed light for every accepted
// request and checks each output in order. The smoothing coefficient is
// reprogrammed over APB between idle phases, including the clamp and
// ignored-address cases.
// ----------------------------------------------------------------------------
module color_hue_and_light_smoother_unit_tb;
  import chls_pkg::*;

  localparam int unsigned DRAIN_CYCLES   = 24;  // pipeline latency plus margin
  localparam int unsigned RAND_PHASES    = 6;
  localparam int unsigned RAND_PER_PHASE = 75;

  // Field layout matches tdata: red in the low bits
  typedef struct packed {
    logic [FIELD_W-1:0] ambient;
    logic [FIELD_W-1:0] blue;
    logic [FIELD_W-1:0] green;
    logic [FIELD_W-1:0] red;
  } sample_t;

  typedef struct packed {
    logic [LIGHT_W-1:0] smoothed;
    logic [LIGHT_W-1:0] change;
    logic [HUE_W-1:0]   hue;
  } result_t;

  // DUT ports
  logic                    clk_i           = 1'b0;
  logic                    rst_ni          = 1'b0;
  logic [IN_DATA_W-1:0]    s_axis_tdata_i  = '0;
  logic                    s_axis_tvalid_i = 1'b0;
  logic                    s_axis_tready_o;
  logic [OUT_DATA_W-1:0]   m_axis_tdata_o;
  logic                    m_axis_tvalid_o;
  logic                    m_axis_tready_i = 1'b0;
  logic                    psel            = 1'b0;
  logic                    penable         = 1'b0;
  logic                    pwrite          = 1'b0;
  logic [APB_ADDR_W-1:0]   paddr           = '0;
  logic [APB_DATA_W-1:0]   pwdata          = '0;
  logic [APB_DATA_W-1:0]   prdata;
  logic                    pready;

  // Predictor state and bookkeeping
  logic [COEF_W-1:0]  coef_model  = COEF_RESET;
  logic [LIGHT_W-1:0] light_model = '0;
  result_t            pending_results[$];
  int unsigned        errors          = 0;
  int unsigned        samples_sent    = 0;
  int unsigned        results_checked = 0;
  int unsigned        coef_writes     = 0;
  bit                 tx_gaps_on      = 1'b1;
  bit                 rx_stalls_on    = 1'b1;
  int unsigned        rx_stall_left   = 0;

  color_hue_and_light_smoother_unit dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  // 12 ns clock
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Watchdog
  initial begin
    #5_000_000;
    $display("Regression FAIL");
    $finish;
  end

  // Hue in 1/64 degree, truncated toward zero, red-max case left unwrapped
  function automatic logic [HUE_W-1:0] predict_hue(sample_t s);
    longint r, g, b, hi, lo, span, num;
    r = s.red & SAMPLE_MASK;
    g = s.green & SAMPLE_MASK;
    b = s.blue & SAMPLE_MASK;
    hi = r;
    lo = r;
    if (g > hi) hi = g;
    if (b > hi) hi = b;
    if (g < lo) lo = g;
    if (b < lo) lo = b;
    if (hi == lo) return '0;
    span = hi - lo;
    // red wins ties, then green
    if (r >= hi) num = g - b;
    else if (g >= hi) num = 2 * span + (b - r);
    else num = 4 * span + (r - g);
    return HUE_W'((num * longint'(HUE_SCALE)) / span);
  endfunction

  // Expected result of one request; advances the smoothed light
  function automatic result_t predict_sample(sample_t s);
    result_t want;
    longint unsigned amb, old, c, next;
    amb = s.ambient & SAMPLE_MASK;
    amb = amb << 8;
    old = light_model;
    c   = coef_model;
    want.hue    = predict_hue(s);
    want.change = LIGHT_W'((amb >= old) ? amb - old : old - amb);
    next = (old * c + (longint'(COEF_ONE) - c) * amb) >> 16;
    light_model   = LIGHT_W'(next);
    want.smoothed = light_model;
    return want;
  endfunction

  function automatic sample_t make_sample(logic [15:0] r, logic [15:0] g,
                                          logic [15:0] b, logic [15:0] a);
    sample_t s;
    s.red     = r;
    s.green   = g;
    s.blue    = b;
    s.ambient = a;
    return s;
  endfunction

  // Source gap: mostly none or short, now and then long
  function automatic int unsigned pick_tx_gap();
    int unsigned roll;
    if (!tx_gaps_on) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Random sample biased toward equal channels, ties, narrow spreads and extremes
  function automatic sample_t random_sample();
    sample_t     s;
    logic [15:0] base;
    int unsigned kind;
    s = sample_t'({$urandom(), $urandom()});
    kind = $urandom_range(0, 9);
    case (kind)
      4: begin
        s.green = s.red;
        s.blue  = s.red;
      end
      5: begin
        case ($urandom_range(0, 2))
          0: s.green = s.red;
          1: s.blue = s.red;
          default: s.blue = s.green;
        endcase
      end
      6: begin
        base    = 16'($urandom_range(0, 65527));
        s.red   = base + 16'($urandom_range(0, 8));
        s.green = base + 16'($urandom_range(0, 8));
        s.blue  = base + 16'($urandom_range(0, 8));
      end
      7: begin
        s.red   = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
        s.green = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
        s.blue  = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
      end
      8: begin
        // ambient close to the smoothed light: small changes
        s.ambient = light_model[LIGHT_W-1:8] + 16'($urandom_range(0, 4)) - 16'd2;
      end
      default: begin
      end
    endcase
    if ($urandom_range(0, 19) == 0) s.ambient = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
    return s;
  endfunction

  // Sink ready: stalls mostly short, a few long, none when disabled
  always @(posedge clk_i) begin : rx_ready_gen
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (rx_stall_left > 0) begin
      m_axis_tready_i <= 1'b0;
      rx_stall_left   <= rx_stall_left - 1;
    end else if (!rx_stalls_on || roll < 70) begin
      m_axis_tready_i <= 1'b1;
    end else if (roll < 95) begin
      m_axis_tready_i <= 1'b0;
      rx_stall_left   <= $urandom_range(0, 3);
    end else begin
      m_axis_tready_i <= 1'b0;
      rx_stall_left   <= $urandom_range(10, 60);
    end
  end

  // Compare each output request with the oldest prediction
  always @(posedge clk_i) begin : result_check
    result_t got, want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      got = result_t'(m_axis_tdata_o);
      if (pending_results.size() == 0) begin
        $error("unexpected result: tdata %h", m_axis_tdata_o);
        errors++;
      end else begin
        want = pending_results.pop_front();
        results_checked++;
        if (got.hue !== want.hue) begin
          $error("hue_angle: expected %0d, got %0d", $signed(want.hue), $signed(got.hue));
          errors++;
        end
        if (got.change !== want.change) begin
          $error("light_change: expected %0d, got %0d", want.change, got.change);
          errors++;
        end
        if (got.smoothed !== want.smoothed) begin
          $error("light_smoothed: expected %0d, got %0d", want.smoothed, got.smoothed);
          errors++;
        end
      end
    end
  end

  // Send one request; valid stays high across back-to-back requests
  task automatic send_sample(sample_t s);
    int unsigned gap;
    gap = pick_tx_gap();
    if (gap > 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tdata_i  <= s;
    s_axis_tvalid_i <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready_o);
    pending_results.push_back(predict_sample(s));
    samples_sent++;
  endtask

  // Stop sending and let every outstanding result drain
  task automatic wait_all_results();
    s_axis_tvalid_i <= 1'b0;
    do @(posedge clk_i); while (pending_results.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // APB write: setup then access; only the coefficient address is decoded
  task automatic write_coef(logic [APB_ADDR_W-1:0] addr, logic [APB_DATA_W-1:0] data);
    logic [COEF_W-1:0] v;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    coef_writes++;
    if (addr == REG_SMOOTHING_COEF) begin
      v = data[COEF_W-1:0];
      coef_model = (v > COEF_ONE) ? COEF_ONE : v;
    end
    @(posedge clk_i);
  endtask

  // Hue extremes, tie rules, truncation of both signs; reset coefficient
  task automatic test_directed_hue();
    send_sample(make_sample(16'h0000, 16'h0000, 16'h0000, 16'h0000));
    send_sample(make_sample(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
    send_sample(make_sample(16'hFFFF, 16'h0000, 16'h0000, 16'h0000));
    send_sample(make_sample(16'hFFFF, 16'hFFFF, 16'h0000, 16'hFFFF));
    send_sample(make_sample(16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000));
    send_sample(make_sample(16'h0000, 16'hFFFF, 16'hFFFF, 16'hAAAA));
    send_sample(make_sample(16'h0000, 16'hFFFF, 16'h0000, 16'h5555));
    send_sample(make_sample(16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF));
    send_sample(make_sample(16'hFFFE, 16'h0000, 16'hFFFF, 16'h0000));
    send_sample(make_sample(16'd1, 16'd0, 16'd2, 16'd1));
    send_sample(make_sample(16'd11, 16'd4, 16'd5, 16'hFFFF));
    send_sample(make_sample(16'd11, 16'd5, 16'd4, 16'h8000));
    send_sample(make_sample(16'd5, 16'd7, 16'd6, 16'h7FFF));
    send_sample(make_sample(16'd100, 16'd103, 16'd100, 16'h0001));
    wait_all_results();
  endtask

  // Coefficient extremes, clamp above one, masked upper bits, ignored addresses
  task automatic test_coef_register();
    write_coef(REG_SMOOTHING_COEF, 32'd0);
    send_sample(make_sample(16'd3, 16'd9, 16'd1, 16'hFFFF));
    send_sample(make_sample(16'd9, 16'd3, 16'd1, 16'h1234));
    wait_all_results();
    write_coef(REG_SMOOTHING_COEF, 32'd65536);
    send_sample(make_sample(16'd1, 16'd3, 16'd9, 16'h0000));
    send_sample(make_sample(16'd7, 16'd7, 16'd7, 16'hFFFF));
    wait_all_results();
    write_coef(REG_SMOOTHING_COEF, 32'd131071);
    send_sample(make_sample(16'd2, 16'd8, 16'd4, 16'h0000));
    wait_all_results();
    write_coef(REG_SMOOTHING_COEF, 32'hFFFF_FFFF);
    send_sample(make_sample(16'd8, 16'd2, 16'd4, 16'hFFFF));
    wait_all_results();
    write_coef(REG_SMOOTHING_COEF, 32'hFFFE_0001);
    send_sample(make_sample(16'hFFFF, 16'h8000, 16'h0001, 16'hF00F));
    wait_all_results();
    // writes to other addresses must leave the coefficient alone
    write_coef(APB_ADDR_W'(1), 32'd0);
    write_coef(APB_ADDR_W'(2), 32'd65536);
    write_coef(APB_ADDR_W'(3), 32'd30000);
    send_sample(make_sample(16'h0F0F, 16'hF0F0, 16'h00FF, 16'h0000));
    send_sample(make_sample(16'h00FF, 16'h0F0F, 16'hF0F0, 16'hFFFF));
    wait_all_results();
    write_coef(REG_SMOOTHING_COEF, 32'd65535);
    send_sample(make_sample(16'h4000, 16'h2000, 16'h6000, 16'hFFFF));
    send_sample(make_sample(16'h2000, 16'h6000, 16'h4000, 16'h0000));
    wait_all_results();
  endtask

  // Random phases, each with its own coefficient and idle pattern
  task automatic test_random_stream();
    logic [COEF_W-1:0] coef;
    for (int phase = 0; phase < RAND_PHASES; phase++) begin
      case (phase)
        0: coef = COEF_RESET;
        2: coef = COEF_ONE - 1'b1;
        3: coef = COEF_W'($urandom_range(65537, 131071));
        4: coef = '0;
        default: coef = COEF_W'($urandom_range(0, 65536));
      endcase
      write_coef(REG_SMOOTHING_COEF, ($urandom() & 32'hFFFE_0000) | APB_DATA_W'(coef));
      tx_gaps_on   = (phase != 2) && (phase != 5);
      rx_stalls_on = (phase != 2) && (phase != 4);
      for (int n = 0; n < RAND_PER_PHASE; n++) begin
        // one full pause mid-stream until the pipeline is empty
        if (phase == 1 && n == RAND_PER_PHASE / 2) wait_all_results();
        send_sample(random_sample());
      end
      wait_all_results();
    end
    tx_gaps_on   = 1'b1;
    rx_stalls_on = 1'b1;
  endtask

  // Main sequence
  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_hue();
    test_coef_register();
    test_random_stream();
    wait_all_results();
    $display("Sent %0d samples, checked %0d results, %0d coefficient writes.",
             samples_sent, results_checked, coef_writes);
    $display("Covered hue sectors, ties, equal channels, coefficient clamp and idle gaps.");
    if (errors == 0 && pending_results.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
